// ----- hw/rtl/clipped_color_key_blit_macros.svh -----
// ----------------------------------------------------------------------------
// Clipped color key blit assertion macros
// Shared concurrent assertion forms for the blitter write stage.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLOR_KEY_BLIT_MACROS_SVH
`define CLIPPED_COLOR_KEY_BLIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCKB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCKB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/cckb_pkg.sv -----
// ----------------------------------------------------------------------------
// Clipped color key blit package
// Shared widths, register indexes and defaults for the blitter write stage.
// ----------------------------------------------------------------------------
package cckb_pkg;

   localparam int PIXEL_BITS   = 16;
   localparam int ADDR_BITS    = 24;
   localparam int COORD_BITS   = 12;
   localparam int PITCH_BITS   = 13;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 13;
   localparam int MAX_DIM_DEF  = 2048;

   localparam logic [COORD_BITS-1:0] SURF_W_RST = 12'd640;
   localparam logic [COORD_BITS-1:0] SURF_H_RST = 12'd480;
   localparam logic [PITCH_BITS-1:0] PITCH_RST  = 13'd640;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_DEST_X      = 3'd0,
      REG_DEST_Y      = 3'd1,
      REG_RECT_WIDTH  = 3'd2,
      REG_RECT_HEIGHT = 3'd3,
      REG_SURF_WIDTH  = 3'd4,
      REG_SURF_HEIGHT = 3'd5,
      REG_ROW_PITCH   = 3'd6,
      REG_BASE_OFFSET = 3'd7
   } csr_index_type;

endpackage

// ----- hw/rtl/cckb_req_if.sv -----
// ----------------------------------------------------------------------------
// Clipped color key blit request channel
// Carries one source pixel per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cckb_req_if import cckb_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] source_pixel;

   modport source (output valid, output source_pixel, input ready);
   modport sink   (input valid, input source_pixel, output ready);

endinterface

// ----- hw/rtl/cckb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Clipped color key blit response channel
// Carries one destination write decision per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cckb_rsp_if import cckb_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  write_enable;
   logic [ADDR_BITS-1:0]  dest_address;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  rect_done;

   modport source (output valid, output write_enable, output dest_address,
                   output pixel_out, output rect_done, input ready);
   modport sink   (input valid, input write_enable, input dest_address,
                   input pixel_out, input rect_done, output ready);

endinterface

// ----- hw/rtl/clipped_color_key_blit.sv -----
// ----------------------------------------------------------------------------
// Clipped color key blit
// An accepted request beat passes through stage 1 and the response register to its response beat.
// Throughput is one pixel per cycle; a stalled response holds both stages.
// Synchronous active-high reset clears counters and valid flags, loads defaults.
// ----------------------------------------------------------------------------
module clipped_color_key_blit import cckb_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   cckb_req_if.sink                 req_bus,
   cckb_rsp_if.source               rsp_bus
);

`include "clipped_color_key_blit_macros.svh"

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int CMP_W = 13;
   localparam int POS_W = 14;
   localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

   logic signed [COORD_BITS-1:0] dest_x_ff, dest_y_ff;
   logic [COORD_BITS-1:0]        rect_w_ff, rect_h_ff, surf_w_ff, surf_h_ff, base_ff;
   logic [PITCH_BITS-1:0]        pitch_ff;

   logic [CNT_W-1:0] col_ff, row_ff, col_in, row_in;

   logic                    s1_valid_ff;
   logic [PIXEL_BITS-1:0]   s1_pixel_ff;
   logic signed [POS_W-1:0] s1_px_ff, s1_py_ff;
   logic                    s1_inside_ff, s1_done_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_we_ff, rsp_done_ff;
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;

   logic                    advance, accept;
   logic [CMP_W-1:0]        col_ext, row_ext, w_eff, h_eff;
   logic                    inside_in, row_end_in, done_in;
   logic signed [POS_W-1:0] px_in, py_in;
   logic                    visible, we_in;
   logic [PITCH_BITS+COORD_BITS-1:0] prod;
   logic [ADDR_BITS-1:0]    addr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff <= '0;
         dest_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         surf_w_ff <= SURF_W_RST;
         surf_h_ff <= SURF_H_RST;
         pitch_ff  <= PITCH_RST;
         base_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_DEST_X:      dest_x_ff <= $signed(csr_wdata[COORD_BITS-1:0]);
            REG_DEST_Y:      dest_y_ff <= $signed(csr_wdata[COORD_BITS-1:0]);
            REG_RECT_WIDTH:  rect_w_ff <= csr_wdata[COORD_BITS-1:0];
            REG_RECT_HEIGHT: rect_h_ff <= csr_wdata[COORD_BITS-1:0];
            REG_SURF_WIDTH:  surf_w_ff <= csr_wdata[COORD_BITS-1:0];
            REG_SURF_HEIGHT: surf_h_ff <= csr_wdata[COORD_BITS-1:0];
            REG_ROW_PITCH:   pitch_ff  <= csr_wdata;
            REG_BASE_OFFSET: base_ff   <= csr_wdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;
   assign accept  = req_bus.valid && req_bus.ready;

   always_comb begin
      col_ext = CMP_W'(col_ff);
      row_ext = CMP_W'(row_ff);
      w_eff = ({1'b0, rect_w_ff} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, rect_w_ff};
      h_eff = ({1'b0, rect_h_ff} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, rect_h_ff};
      inside_in  = (col_ext < w_eff) && (row_ext < h_eff);
      row_end_in = (col_ext + CMP_W'(1)) >= w_eff;
      done_in    = row_end_in && ((row_ext + CMP_W'(1)) >= h_eff);
      px_in = POS_W'(dest_x_ff) + $signed(POS_W'(col_ff));
      py_in = POS_W'(dest_y_ff) + $signed(POS_W'(row_ff));
      if (done_in) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end_in) begin
         col_in = '0;
         row_in = row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (accept) begin
         s1_pixel_ff  <= req_bus.source_pixel;
         s1_px_ff     <= px_in;
         s1_py_ff     <= py_in;
         s1_inside_ff <= inside_in;
         s1_done_ff   <= done_in;
      end
   end

   always_comb begin
      visible = s1_inside_ff &&
                !s1_px_ff[POS_W-1] && (s1_px_ff < $signed(POS_W'(surf_w_ff))) &&
                !s1_py_ff[POS_W-1] && (s1_py_ff < $signed(POS_W'(surf_h_ff)));
      we_in = visible && (s1_pixel_ff != '0);
      prod  = s1_py_ff[COORD_BITS-1:0] * pitch_ff;
      addr_in = ADDR_BITS'(prod) + ADDR_BITS'(base_ff) +
                ADDR_BITS'(s1_px_ff[COORD_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         rsp_we_ff    <= we_in;
         rsp_addr_ff  <= we_in ? addr_in : '0;
         rsp_pixel_ff <= we_in ? s1_pixel_ff : '0;
         rsp_done_ff  <= s1_done_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.write_enable = rsp_we_ff;
   assign rsp_bus.dest_address = rsp_addr_ff;
   assign rsp_bus.pixel_out    = rsp_pixel_ff;
   assign rsp_bus.rect_done    = rsp_done_ff;

   `CCKB_ASSERT_NOW(a_key_never_written, clock, reset, rsp_valid_ff && rsp_we_ff,
                    rsp_pixel_ff != '0, "transparent pixel written")
   `CCKB_ASSERT_NOW(a_idle_fields_zero, clock, reset, rsp_valid_ff && !rsp_we_ff,
                    rsp_addr_ff == '0 && rsp_pixel_ff == '0, "clipped beat carries data")
   `CCKB_ASSERT_NEXT(a_done_clears_counters, clock, reset, accept && done_in,
                     col_ff == '0 && row_ff == '0, "counters not cleared after rectangle end")
   `CCKB_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_bus.ready,
                    !req_bus.ready, "request taken while response stalled")

endmodule
